### hdl/tccw_pkg.sv
package tccw_pkg;

	localparam int ROWS = 25;
	localparam int COLS = 80;
	localparam int ROW_W = 5;
	localparam int COL_W = 7;
	localparam int DEPTH = ROWS * COLS;
	localparam int ADDR_W = $clog2(DEPTH);

	localparam logic [1:0] KIND_PUT = 2'd0;
	localparam logic [1:0] KIND_READ = 2'd1;
	localparam logic [1:0] KIND_BLINK = 2'd2;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [3:0] {
		ST_CLEAR  = 4'b0001,
		ST_IDLE   = 4'b0010,
		ST_READ   = 4'b0100,
		ST_SCROLL = 4'b1000
	} state_t;

endpackage

### hdl/text_console_char_writer_core.sv
// Results: put, blink and unused-kind items give their result in the cycle after the transfer;
// a read cell item gives it after the memory read register and then the output register.
// Throughput: one put or blink per cycle while the output is not stalled; a read blocks new
// items until its result is loaded; a put that scrolls the screen blocks new items while the
// freed row is filled with spaces. Reset: arst_n clears the cursor and the top-row offset and
// sets the blink phase to visible, then a clearing pass writes spaces to the whole grid first.
module text_console_char_writer_core import tccw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        kind,
	input  logic [7:0]        char_code,
	input  logic [ROW_W-1:0]  read_row,
	input  logic [COL_W-1:0]  read_col,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        cell_char,
	output logic [COL_W-1:0]  cursor_col,
	output logic [ROW_W-1:0]  cursor_row,
	output logic              cursor_visible
);

	// The character grid is one synchronous memory. Rows are stored in
	// circular order: physical row top_q holds screen row 0.
	logic [7:0]        grid_mem [DEPTH];
	logic [7:0]        rd_data_q;

	state_t            state_q;
	logic [ADDR_W-1:0] sweep_addr_q;
	logic [COL_W-1:0]  sweep_col_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  line_q;
	logic [ROW_W-1:0]  top_q;
	logic              blink_q;
	logic              rd_oob_s1;

	logic              out_valid_q;
	logic [7:0]        cell_char_q;
	logic [COL_W-1:0]  cursor_col_q;
	logic [ROW_W-1:0]  cursor_row_q;
	logic              cursor_visible_q;

	logic              accept;
	logic              out_take;
	logic              out_load;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [7:0]        mem_wdata;
	logic [ADDR_W-1:0] mem_raddr;
	logic              rd_oob;

	logic [COL_W-1:0]  col_nx;
	logic [ROW_W-1:0]  line_nx;
	logic [ROW_W-1:0]  top_nx;
	logic              blink_nx;
	logic              put_write;
	logic              do_scroll;

	logic [ROW_W:0]    put_phys_sum;
	logic [ROW_W-1:0]  put_phys;
	logic [ROW_W:0]    rd_phys_sum;
	logic [ROW_W-1:0]  rd_phys;
	logic [ADDR_W-1:0] put_addr;

	// An item is taken only when the sequencer is idle and the output
	// register is free or its result leaves in this same cycle.
	assign out_take = out_valid_q && !out_stall;
	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign accept = in_valid && !in_stall;

	// A new result enters the output register for a put, blink or unused kind
	// at its transfer, and for a read in the cycle after its transfer.
	assign out_load = (state_q == ST_READ) || (accept && kind != KIND_READ);

	// Screen row to physical row: both operands are below ROWS, so one
	// conditional subtract wraps the sum.
	assign put_phys_sum = {1'b0, top_q} + {1'b0, line_q};
	assign put_phys = (put_phys_sum >= (ROW_W+1)'(ROWS)) ?
		ROW_W'(put_phys_sum - (ROW_W+1)'(ROWS)) : put_phys_sum[ROW_W-1:0];
	assign rd_phys_sum = {1'b0, top_q} + {1'b0, read_row};
	assign rd_phys = (rd_phys_sum >= (ROW_W+1)'(ROWS)) ?
		ROW_W'(rd_phys_sum - (ROW_W+1)'(ROWS)) : rd_phys_sum[ROW_W-1:0];

	assign put_addr = ADDR_W'(put_phys * COLS) + ADDR_W'(col_q);

	// Reads outside the grid return zero; the address is parked at zero so
	// the memory is never indexed beyond its depth.
	assign rd_oob = (read_row >= ROW_W'(ROWS)) || (read_col >= COL_W'(COLS));
	assign mem_raddr = rd_oob ? '0 : ADDR_W'(rd_phys * COLS) + ADDR_W'(read_col);

	// Cursor update for the item being transferred.
	always_comb begin
		col_nx = col_q;
		line_nx = line_q;
		top_nx = top_q;
		blink_nx = blink_q;
		put_write = 1'b0;
		do_scroll = 1'b0;
		case (kind)
			KIND_PUT: begin
				if (char_code == CH_CR) begin
					col_nx = '0;
				end else if (char_code != CH_NUL) begin
					// Line feed, or any other character that fills the last column,
					// starts a new line.
					if (char_code != CH_LF) begin
						put_write = 1'b1;
					end
					if (char_code == CH_LF || col_q == COL_W'(COLS - 1)) begin
						col_nx = '0;
						if (line_q == ROW_W'(ROWS - 1)) begin
							do_scroll = 1'b1;
							top_nx = (top_q == ROW_W'(ROWS - 1)) ? '0 : top_q + 1'b1;
						end else begin
							line_nx = line_q + 1'b1;
						end
					end else begin
						col_nx = col_q + 1'b1;
					end
				end
			end
			KIND_BLINK: begin
				blink_nx = ~blink_q;
			end
			default: begin
			end
		endcase
	end

	// One write port, shared by the put path and the space-filling sweeps.
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = put_addr;
		mem_wdata = char_code;
		case (state_q)
			ST_CLEAR, ST_SCROLL: begin
				mem_we = 1'b1;
				mem_waddr = sweep_addr_q;
				mem_wdata = CH_SPACE;
			end
			ST_IDLE: begin
				mem_we = accept && put_write;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= grid_mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			sweep_addr_q <= '0;
			sweep_col_q <= '0;
			col_q <= '0;
			line_q <= '0;
			top_q <= '0;
			blink_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					sweep_addr_q <= sweep_addr_q + 1'b1;
					if (sweep_addr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						col_q <= col_nx;
						line_q <= line_nx;
						top_q <= top_nx;
						blink_q <= blink_nx;
						if (kind == KIND_READ) begin
							state_q <= ST_READ;
						end else if (do_scroll) begin
							// The old top row becomes the new bottom row.
							state_q <= ST_SCROLL;
							sweep_addr_q <= ADDR_W'(top_q * COLS);
							sweep_col_q <= '0;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_IDLE;
				end
				ST_SCROLL: begin
					sweep_addr_q <= sweep_addr_q + 1'b1;
					sweep_col_q <= sweep_col_q + 1'b1;
					if (sweep_col_q == COL_W'(COLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result payload. Reads fill it in the cycle after the transfer, when the
	// memory data is available.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			rd_oob_s1 <= rd_oob;
			if (kind != KIND_READ) begin
				cell_char_q <= '0;
				cursor_col_q <= col_nx;
				cursor_row_q <= line_nx;
				cursor_visible_q <= blink_nx;
			end
		end else if (state_q == ST_READ) begin
			cell_char_q <= rd_oob_s1 ? '0 : rd_data_q;
			cursor_col_q <= col_q;
			cursor_row_q <= line_q;
			cursor_visible_q <= blink_q;
		end
	end

	assign out_valid = out_valid_q;
	assign cell_char = cell_char_q;
	assign cursor_col = cursor_col_q;
	assign cursor_row = cursor_row_q;
	assign cursor_visible = cursor_visible_q;

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

// Self-checking bench for the text console character writer. Items go in
// through one valid/stall channel and results come out through another. A
// mirror of the grid, the cursor, the top-row offset and the blink phase is
// kept here. It is updated on every accepted input transfer, and every
// output transfer is checked field by field against the oldest pending
// status.
module testbench;
	import tccw_pkg::*;

	// Kind 3 has no function in the block, so it must leave all state alone.
	localparam logic [1:0] KIND_SPARE = 2'd3;
	// The receiver holds off this long once during the back-pressure test.
	localparam int LONG_HOLD_CYCLES = 300;
	// Quiet time after the last result, so that a stray extra result shows up.
	localparam int SETTLE_CYCLES = 16;
	localparam int PRINT_CAP = 40;

	typedef struct packed {
		logic [7:0]       char_val;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             vis;
	} console_status_t;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [1:0]       kind;
	logic [7:0]       char_code;
	logic [ROW_W-1:0] read_row;
	logic [COL_W-1:0] read_col;
	logic             out_valid;
	logic             out_stall;
	logic [7:0]       cell_char;
	logic [COL_W-1:0] cursor_col;
	logic [ROW_W-1:0] cursor_row;
	logic             cursor_visible;

	// This is the mirror of the block's state. The grid is stored by physical
	// row, and mirror_top is the physical row that holds screen row 0.
	logic [7:0]      grid_mirror [DEPTH];
	int              mirror_col;
	int              mirror_row;
	int              mirror_top;
	logic            mirror_blink;

	console_status_t status_q [$];
	int              mismatch_count = 0;

	// These switches shape the idling on both sides. They are set by the main sequence and the test tasks.
	bit tx_gaps_on = 1'b0;
	bit rx_stalls_on = 1'b0;
	bit long_hold_req = 1'b0;

	text_console_char_writer_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.char_code      (char_code),
		.read_row       (read_row),
		.read_col       (read_col),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.cell_char      (cell_char),
		.cursor_col     (cursor_col),
		.cursor_row     (cursor_row),
		.cursor_visible (cursor_visible)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// The run is ended here if the traffic ever locks up.
	initial begin
		#4_000_000;
		$display("Regression FAIL");
		$finish;
	end

	task automatic flag_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP) begin
			$display("%0t: mismatch on %s, got %0d, wanted %0d", $realtime, what, got, want);
		end
	endtask

	// A new line moves the cursor to column zero of the next row. Below the
	// last row, the oldest physical row is blanked and becomes the bottom row.
	function automatic void mirror_line_feed();
		int freed;
		mirror_col = 0;
		mirror_row++;
		if (mirror_row >= ROWS) begin
			freed = mirror_top;
			for (int i = 0; i < COLS; i++) begin
				grid_mirror[freed * COLS + i] = CH_SPACE;
			end
			mirror_top = (mirror_top + 1) % ROWS;
			mirror_row = ROWS - 1;
		end
	endfunction

	// This function applies one accepted item to the mirror and returns the
	// status that the block must report for it.
	function automatic console_status_t console_apply(input logic [1:0] k,
			input logic [7:0] c, input logic [ROW_W-1:0] r, input logic [COL_W-1:0] cl);
		console_status_t s;
		s = '0;
		case (k)
			KIND_PUT: begin
				if (c == CH_LF) begin
					mirror_line_feed();
				end else if (c == CH_CR) begin
					mirror_col = 0;
				end else if (c != CH_NUL) begin
					grid_mirror[((mirror_top + mirror_row) % ROWS) * COLS + mirror_col] = c;
					mirror_col++;
					if (mirror_col >= COLS) begin
						mirror_line_feed();
					end
				end
			end
			KIND_READ: begin
				// A read outside the grid returns zero.
				if (r < ROWS && cl < COLS) begin
					s.char_val = grid_mirror[((mirror_top + r) % ROWS) * COLS + cl];
				end
			end
			KIND_BLINK: begin
				mirror_blink = ~mirror_blink;
			end
			default: begin
			end
		endcase
		s.col = COL_W'(mirror_col);
		s.row = ROW_W'(mirror_row);
		s.vis = mirror_blink;
		return s;
	endfunction

	// Both handshakes are sampled at the rising edge, before the block's
	// registers update. A result never belongs to an item that was accepted
	// at the same edge, so the order of the check and the push does not
	// matter.
	always @(posedge clk) begin : track_transfers
		console_status_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (status_q.size() == 0) begin
				flag_mismatch("result with no pending item", 1, 0);
			end else begin
				want = status_q.pop_front();
				if (cell_char !== want.char_val) begin
					flag_mismatch("cell_char", cell_char, want.char_val);
				end
				if (cursor_col !== want.col) begin
					flag_mismatch("cursor_col", cursor_col, want.col);
				end
				if (cursor_row !== want.row) begin
					flag_mismatch("cursor_row", cursor_row, want.row);
				end
				if (cursor_visible !== want.vis) begin
					flag_mismatch("cursor_visible", cursor_visible, want.vis);
				end
			end
		end
		if (arst_n && in_valid && !in_stall) begin
			status_q.push_back(console_apply(kind, char_code, read_row, read_col));
		end
	end

	// The receiver stalls in random bursts. When the back-pressure test
	// requests it, the receiver also does one long hold-off, counted here.
	initial begin : receiver_stall
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				long_hold_req = 1'b0;
			end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// This task offers one item and returns at the edge where its transfer
	// takes place. The payload is held steady for as long as the block stalls.
	task automatic send_item(input logic [1:0] k, input logic [7:0] c,
			input logic [ROW_W-1:0] r, input logic [COL_W-1:0] cl);
		if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		kind      <= k;
		char_code <= c;
		read_row  <= r;
		read_col  <= cl;
		do @(posedge clk); while (in_stall);
	endtask

	// The fields that the kind ignores are filled with random values.
	task automatic send_put(input logic [7:0] c);
		send_item(KIND_PUT, c, ROW_W'($urandom), COL_W'($urandom));
	endtask

	task automatic send_read(input int r, input int cl);
		send_item(KIND_READ, 8'($urandom), ROW_W'(r), COL_W'(cl));
	endtask

	task automatic send_printable();
		send_put(8'($urandom_range(32, 126)));
	endtask

	// The sender stops and waits until every pending status has been returned.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (status_q.size() != 0);
	endtask

	// Most items look like real console traffic: text, line breaks, reads
	// near the cursor, and blinks. The rest are noise: any byte including
	// NUL, reads with full-width coordinates, and the unused kind.
	task automatic send_random_item();
		int               pick;
		logic [ROW_W-1:0] rr;
		logic [COL_W-1:0] rc;
		pick = $urandom_range(0, 99);
		rr = ROW_W'($urandom);
		rc = COL_W'($urandom);
		if (pick < 58) begin
			send_printable();
		end else if (pick < 64) begin
			send_put(CH_LF);
		end else if (pick < 67) begin
			send_put(CH_CR);
		end else if (pick < 82) begin
			if ($urandom_range(0, 1) != 0) begin
				rr = ROW_W'(mirror_row);
			end else begin
				rr = ROW_W'($urandom_range(0, ROWS - 1));
			end
			send_item(KIND_READ, 8'($urandom), rr, COL_W'($urandom_range(0, COLS - 1)));
		end else if (pick < 89) begin
			send_item(KIND_BLINK, 8'($urandom), rr, rc);
		end else if (pick < 94) begin
			send_item(KIND_PUT, 8'($urandom), rr, rc);
		end else if (pick < 97) begin
			send_item(KIND_READ, 8'($urandom), rr, rc);
		end else begin
			send_item(KIND_SPARE, 8'($urandom), rr, rc);
		end
	endtask

	// This test covers the grid after the clearing pass, extreme character
	// codes, the null character, carriage return, line feed, blink, the
	// unused kind, and reads just outside and far outside the grid.
	task automatic test_directed();
		send_read(0, 0);
		send_read(ROWS - 1, COLS - 1);
		send_put(8'h41);
		send_put(8'hFF);
		send_put(8'h80);
		send_put(8'h01);
		send_put(CH_NUL);
		for (int i = 0; i < 5; i++) begin
			send_read(0, i);
		end
		send_put(CH_CR);
		send_put(8'h7F);
		send_put(CH_LF);
		send_item(KIND_BLINK, 8'h00, '0, '0);
		send_item(KIND_BLINK, 8'hFF, '1, '1);
		send_item(KIND_SPARE, 8'hFF, '1, '1);
		send_read(ROWS, 0);
		send_read(0, COLS);
		send_read(31, 127);
		send_read(0, 0);
	endtask

	// This test writes a little more than one full line, so that the column
	// wraps without a line feed. It then reads the line back.
	task automatic test_line_wrap();
		send_put(CH_CR);
		for (int i = 0; i < COLS + 5; i++) begin
			send_printable();
		end
		for (int i = 0; i < COLS; i += 9) begin
			send_read(mirror_row - 1, i);
			send_read(mirror_row, i);
		end
		send_read(mirror_row - 1, COLS - 1);
	endtask

	// This test sends enough short lines to scroll the screen several times.
	// It then fills the bottom row completely, so that the column wrap scrolls
	// it too, and reads the rows that moved and the freed bottom row.
	task automatic test_scroll();
		for (int ln = 0; ln < ROWS + 6; ln++) begin
			repeat ($urandom_range(0, 4)) send_printable();
			send_put(CH_LF);
		end
		for (int i = 0; i < COLS; i += 13) begin
			send_read(0, i);
			send_read(ROWS - 2, i);
			send_read(ROWS - 1, i);
		end
		send_put(CH_CR);
		for (int i = 0; i < COLS; i++) begin
			send_printable();
		end
		send_read(ROWS - 2, 0);
		send_read(ROWS - 2, COLS - 1);
		send_read(ROWS - 1, 0);
		send_read(ROWS - 1, COLS - 1);
	endtask

	// In this test the receiver holds off for a long stretch while the sender
	// offers items back to back. The block fills up and stalls its input.
	// Afterwards the sender waits until every pending status has been returned.
	task automatic test_backpressure();
		tx_gaps_on = 1'b0;
		rx_stalls_on = 1'b0;
		long_hold_req = 1'b1;
		repeat (60) send_random_item();
		drain_results();
	endtask

	// This test sends random traffic. With idle_mix set, the idling on both
	// sides is chosen again every hundred items, so that some stretches have
	// no idling at all.
	task automatic test_random(input int count, input bit idle_mix);
		tx_gaps_on = 1'b0;
		rx_stalls_on = 1'b0;
		for (int i = 0; i < count; i++) begin
			if (idle_mix && i % 100 == 0) begin
				tx_gaps_on = $urandom_range(0, 3) != 0;
				rx_stalls_on = $urandom_range(0, 3) != 0;
			end
			send_random_item();
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		kind      <= KIND_PUT;
		char_code <= CH_NUL;
		read_row  <= '0;
		read_col  <= '0;
		for (int i = 0; i < DEPTH; i++) begin
			grid_mirror[i] = CH_SPACE;
		end
		mirror_col = 0;
		mirror_row = 0;
		mirror_top = 0;
		mirror_blink = 1'b1;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// The block clears its grid after reset. The first transfer simply
		// waits until the block stops stalling its input.
		tx_gaps_on = 1'b1;
		rx_stalls_on = 1'b1;
		test_directed();
		test_line_wrap();
		test_scroll();
		drain_results();
		test_backpressure();
		test_random(750, 1'b1);
		test_random(150, 1'b0);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
